FILE: rtl/hbf_pkg.sv
// hbf_pkg: shared types and codes for the histogram bin finder
// used by hbf_cell and histogram_bin_finder; depends on nothing
`timescale 1ns / 1ps

package hbf_pkg;

   // input word function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   // binning modes
   localparam logic MODE_VARIABLE = 1'b0;
   localparam logic MODE_UNIFORM  = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINNING_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH   = 2'd3;

   localparam int unsigned DATA_W = 32;

   // control flags that travel with a sample along the cell row
   typedef struct packed {
      logic valid;
      logic under;
      logic over;
   } hbf_flags_type;

endpackage

FILE: rtl/histogram_bin_finder.sv
// histogram_bin_finder: maps a Q16.16 sample to a histogram bin index
// top level; depends on hbf_pkg and hbf_cell
//
// usage
// - input channel: a word is taken at a rising edge with start high and busy
//   low. req_func selects a load (write req_edge_value into edge slot
//   req_edge_index, slots above MAX_BINS ignored) or a find (classify
//   req_sample). a load is written at that edge and gives no result
// - result channel: a find gives one word, rsp_bin_index, shown for one cycle
//   with rsp_valid high. 0 is underflow, 1..n a bin, n+1 overflow
// - timing: a find passes the entry register, the multiply register, the row of
//   MAX_BINS+1 cells and the output register; busy drops at the same edge that
//   raises the strobe, so a new word is taken only once the last find is through
// - the receiver cannot stall: the result word is simply strobed
// - csr port: write-only, index per register list, taken when csr_we is high;
//   write only while busy is low
// - reset: registers go to uniform mode, one bin over [0, 1); edge slots are
//   not cleared and must be loaded before variable mode uses them
`timescale 1ns / 1ps

module histogram_bin_finder #(
   parameter int unsigned MAX_BINS = 64
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic                                        req_func,
   input  logic [$clog2(MAX_BINS+2)-1:0]               req_edge_index,
   input  logic signed [hbf_pkg::DATA_W-1:0]           req_edge_value,
   input  logic signed [hbf_pkg::DATA_W-1:0]           req_sample,
   output logic                                        rsp_valid,
   output logic [$clog2(MAX_BINS+2)-1:0]               rsp_bin_index,
   input  logic                                        csr_we,
   input  logic [hbf_pkg::CSR_INDEX_W-1:0]             csr_index,
   input  logic [hbf_pkg::DATA_W-1:0]                  csr_wdata
);
   import hbf_pkg::*;

   localparam int unsigned IDX_W   = $clog2(MAX_BINS + 2);
   localparam int unsigned ACC_W   = DATA_W + $clog2(MAX_BINS + 2);
   localparam int unsigned N_CELLS = MAX_BINS + 1;
   localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_BINS);
   localparam logic [IDX_W-1:0] ONE_N = IDX_W'(1);

   // configuration registers
   logic                     binning_mode_ff;
   logic [IDX_W-1:0]         bin_count_ff;
   logic signed [DATA_W-1:0] range_low_ff, range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         binning_mode_ff <= MODE_UNIFORM;
         bin_count_ff    <= ONE_N;
         range_low_ff    <= '0;
         range_high_ff   <= 32'sd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BINNING_MODE: binning_mode_ff <= csr_wdata[0];
            CSR_BIN_COUNT:    bin_count_ff    <= csr_wdata[IDX_W-1:0];
            CSR_RANGE_LOW:    range_low_ff    <= csr_wdata;
            CSR_RANGE_HIGH:   range_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // bin count clamped into 1..MAX_BINS
   logic [IDX_W-1:0] n_eff;
   always_comb begin
      if (bin_count_ff == '0) begin
         n_eff = ONE_N;
      end else if (bin_count_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = bin_count_ff;
      end
   end

   // handshake
   logic accept, load_go, find_go;
   assign accept  = start & ~busy;
   assign load_go = accept & (req_func == FUNC_LOAD);
   assign find_go = accept & (req_func == FUNC_FIND);

   // entry stage: range checks and offsets for uniform mode
   logic signed [DATA_W:0]   diff_wide, den_wide;
   hbf_flags_type            a_flags_ff, a_flags_in;
   logic [DATA_W-1:0]        a_d_ff, den_ff;
   logic signed [DATA_W-1:0] a_x_ff;

   always_comb begin
      diff_wide = {req_sample[DATA_W-1], req_sample}
                - {range_low_ff[DATA_W-1], range_low_ff};
      den_wide  = {range_high_ff[DATA_W-1], range_high_ff}
                - {range_low_ff[DATA_W-1], range_low_ff};
      a_flags_in.valid = find_go;
      // variable mode sets its flags inside the row, from the edges
      a_flags_in.under = (binning_mode_ff == MODE_UNIFORM) && (req_sample < range_low_ff);
      a_flags_in.over  = (binning_mode_ff == MODE_UNIFORM) && (req_sample >= range_high_ff)
                         && !(req_sample < range_low_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
      end else begin
         a_flags_ff <= a_flags_in;
      end
      if (find_go) begin
         a_x_ff <= req_sample;
         a_d_ff <= diff_wide[DATA_W-1:0];
         den_ff <= den_wide[DATA_W-1:0];
      end
   end

   // multiply stage: target n*(x-low)
   hbf_flags_type            b_flags_ff;
   logic signed [DATA_W-1:0] b_x_ff;
   logic [ACC_W-1:0]         b_t_ff, b_t_in;

   assign b_t_in = {{(ACC_W-DATA_W){1'b0}}, a_d_ff} * {{(ACC_W-IDX_W){1'b0}}, n_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_flags_ff <= '0;
      end else begin
         b_flags_ff <= a_flags_ff;
      end
      b_x_ff <= a_x_ff;
      b_t_ff <= b_t_in;
   end

   // cell row: link k feeds cell k, link k+1 carries its output
   hbf_flags_type            flags_w [N_CELLS+1];
   logic signed [DATA_W-1:0] x_w     [N_CELLS+1];
   logic [ACC_W-1:0]         t_w     [N_CELLS+1];
   logic [ACC_W-1:0]         acc_w   [N_CELLS+1];
   logic [IDX_W-1:0]         count_w [N_CELLS+1];
   logic [N_CELLS:0]         row_valid;

   assign flags_w[0] = b_flags_ff;
   assign x_w[0]     = b_x_ff;
   assign t_w[0]     = b_t_ff;
   assign acc_w[0]   = '0;
   assign count_w[0] = '0;

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      hbf_cell #(
         .CELL_IDX (k),
         .IDX_W    (IDX_W),
         .ACC_W    (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .mode      (binning_mode_ff),
         .n_eff     (n_eff),
         .den       (den_ff),
         .wr_en     (load_go),
         .wr_index  (req_edge_index),
         .wr_value  (req_edge_value),
         .flags_in  (flags_w[k]),
         .x_in      (x_w[k]),
         .t_in      (t_w[k]),
         .acc_in    (acc_w[k]),
         .count_in  (count_w[k]),
         .flags_out (flags_w[k+1]),
         .x_out     (x_w[k+1]),
         .t_out     (t_w[k+1]),
         .acc_out   (acc_w[k+1]),
         .count_out (count_w[k+1])
      );
   end

   for (genvar k = 0; k <= N_CELLS; k++) begin : g_valid
      assign row_valid[k] = flags_w[k].valid;
   end

   // output register and busy
   hbf_flags_type    tail;
   logic             rsp_valid_ff, busy_ff, busy_in;
   logic [IDX_W-1:0] rsp_bin_index_ff, rsp_bin_index_in;

   always_comb begin
      tail = flags_w[N_CELLS];
      if (tail.under) begin
         rsp_bin_index_in = '0;
      end else if (tail.over) begin
         rsp_bin_index_in = n_eff + ONE_N;
      end else begin
         rsp_bin_index_in = count_w[N_CELLS];
      end
      busy_in = busy_ff;
      if (find_go) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= tail.valid;
         busy_ff      <= busy_in;
      end
      if (tail.valid) begin
         rsp_bin_index_ff <= rsp_bin_index_in;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_index_ff;

   // checks
   a_one_sample: assert property (@(posedge clock) disable iff (reset)
      ($countones({row_valid, a_flags_ff.valid}) <= 1))
      else $error("more than one sample in flight");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> ((row_valid == '0) && !a_flags_ff.valid))
      else $error("sample in flight while idle");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a find in progress");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      load_go |=> !rsp_valid)
      else $error("load produced a result word");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bin_index <= n_eff + ONE_N))
      else $error("bin index beyond overflow bin");

endmodule

FILE: rtl/hbf_cell.sv
// hbf_cell: one cell of the bin finder row, holds one edge and counts one step
// depends on hbf_pkg
`timescale 1ns / 1ps

module hbf_cell #(
   parameter int unsigned CELL_IDX = 0,
   parameter int unsigned IDX_W    = 7,
   parameter int unsigned ACC_W    = 39
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mode,
   input  logic [IDX_W-1:0]                    n_eff,
   input  logic [hbf_pkg::DATA_W-1:0]          den,
   input  logic                                wr_en,
   input  logic [IDX_W-1:0]                    wr_index,
   input  logic signed [hbf_pkg::DATA_W-1:0]   wr_value,
   input  hbf_pkg::hbf_flags_type              flags_in,
   input  logic signed [hbf_pkg::DATA_W-1:0]   x_in,
   input  logic [ACC_W-1:0]                    t_in,
   input  logic [ACC_W-1:0]                    acc_in,
   input  logic [IDX_W-1:0]                    count_in,
   output hbf_pkg::hbf_flags_type              flags_out,
   output logic signed [hbf_pkg::DATA_W-1:0]   x_out,
   output logic [ACC_W-1:0]                    t_out,
   output logic [ACC_W-1:0]                    acc_out,
   output logic [IDX_W-1:0]                    count_out
);
   import hbf_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
   localparam bit IS_FIRST = (CELL_IDX == 0);

   logic signed [DATA_W-1:0] edge_ff;
   hbf_flags_type            flags_ff, flags_in_c;
   logic signed [DATA_W-1:0] x_ff;
   logic [ACC_W-1:0]         t_ff, acc_ff, acc_in_c;
   logic [IDX_W-1:0]         count_ff, count_in_c;
   logic                     enabled, hit;

   always_comb begin
      enabled = (MY_IDX <= n_eff);
      if (mode == MODE_UNIFORM) begin
         hit = (acc_in <= t_in);          // k*den <= n*(x-low)
      end else begin
         hit = (edge_ff <= x_in);
      end
      count_in_c = count_in + {{(IDX_W-1){1'b0}}, (enabled & hit)};
      acc_in_c   = acc_in + {{(ACC_W-DATA_W){1'b0}}, den};
      flags_in_c = flags_in;
      if (mode == MODE_VARIABLE) begin
         if (IS_FIRST) begin
            flags_in_c.under = ~hit;      // below the first edge
         end
         if (MY_IDX == n_eff) begin
            flags_in_c.over = hit;        // at or above the last edge
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_index == MY_IDX)) begin
         edge_ff <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in_c;
      end
      x_ff     <= x_in;
      t_ff     <= t_in;
      acc_ff   <= acc_in_c;
      count_ff <= count_in_c;
   end

   assign flags_out = flags_ff;
   assign x_out     = x_ff;
   assign t_out     = t_ff;
   assign acc_out   = acc_ff;
   assign count_out = count_ff;

endmodule

FILE: dv/histogram_bin_finder_tb.sv
// histogram_bin_finder_tb: self-checking testbench for the histogram bin finder
// drives load and find words and compares every strobed bin against a predictor
// depends on hbf_pkg and histogram_bin_finder
`timescale 1ns / 1ps

module histogram_bin_finder_tb;
   import hbf_pkg::*;

   localparam int MAX_BINS = 64;
   localparam int IDX_W = $clog2(MAX_BINS + 2);
   // a find walks the whole cell row before busy drops
   localparam int LATENCY = MAX_BINS + 4;
   localparam int PHASES = 16;
   localparam int WORDS_PER_PHASE = 90;

   localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

   // one input word as the block sees it
   typedef struct packed {
      logic              func;
      logic [IDX_W-1:0]  edge_index;
      logic [DATA_W-1:0] edge_value;
      logic [DATA_W-1:0] sample;
   } bin_request_type;

   // tracks registers and edge slots, predicts each bin and checks it
   class bin_scoreboard_type;
      logic              binning_mode;
      logic [6:0]        bin_count;
      logic [DATA_W-1:0] range_low;
      logic [DATA_W-1:0] range_high;
      logic [DATA_W-1:0] edge_slot [MAX_BINS+1];
      logic [IDX_W-1:0]  pending_bins [$];
      int                failures;

      function new();
         binning_mode = MODE_UNIFORM;
         bin_count    = 7'd1;
         range_low    = '0;
         range_high   = Q_ONE;
         failures     = 0;
         foreach (edge_slot[i]) edge_slot[i] = '0;
      endfunction

      function int bins_in_use(int count);
         if (count < 1) return 1;
         if (count > MAX_BINS) return MAX_BINS;
         return count;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
         case (index)
            CSR_BINNING_MODE: binning_mode = data[0];
            CSR_BIN_COUNT:    bin_count = data[6:0];
            CSR_RANGE_LOW:    range_low = data;
            CSR_RANGE_HIGH:   range_high = data;
            default: ;
         endcase
      endfunction

      function logic [IDX_W-1:0] bin_of_sample(logic [DATA_W-1:0] sample);
         longint x, lo, hi;
         int n, hits;
         n = bins_in_use(int'(bin_count));
         x = longint'(signed'(sample));
         if (binning_mode == MODE_UNIFORM) begin
            lo = longint'(signed'(range_low));
            hi = longint'(signed'(range_high));
         end else begin
            lo = longint'(signed'(edge_slot[0]));
            hi = longint'(signed'(edge_slot[n]));
         end
         if (x < lo) return '0;
         if (x >= hi) return IDX_W'(n + 1);
         if (binning_mode == MODE_UNIFORM) return IDX_W'((x - lo) * n / (hi - lo) + 1);
         hits = 0;
         for (int i = 0; i <= n; i++) begin
            if (longint'(signed'(edge_slot[i])) <= x) hits++;
         end
         return IDX_W'(hits);
      endfunction

      function void note_word(bin_request_type w);
         if (w.func == FUNC_LOAD) begin
            if (w.edge_index <= MAX_BINS) edge_slot[w.edge_index] = w.edge_value;
         end else begin
            pending_bins = {pending_bins, bin_of_sample(w.sample)};
         end
      endfunction

      function void check_bin(logic [IDX_W-1:0] got);
         logic [IDX_W-1:0] want;
         if (pending_bins.size() == 0) begin
            $error("rsp_bin_index: expected nothing, actual %0d", got);
            failures++;
            return;
         end
         want = pending_bins.pop_front();
         if (got !== want) begin
            $error("rsp_bin_index: expected %0d, actual %0d", want, got);
            failures++;
         end
      endfunction

      function void check_drained();
         if (pending_bins.size() != 0) begin
            $error("rsp_bin_index: %0d expected words never came", pending_bins.size());
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [IDX_W-1:0]  req_edge_index;
   logic [DATA_W-1:0] req_edge_value;
   logic [DATA_W-1:0] req_sample;
   logic              rsp_valid;
   logic [IDX_W-1:0]  rsp_bin_index;
   logic              csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;

   bin_scoreboard_type sb;

   // stimulus-side view of the settings and loaded edges, used only to aim samples
   logic              plan_mode;
   int                plan_bins;
   logic [DATA_W-1:0] plan_low;
   logic [DATA_W-1:0] plan_high;
   logic [DATA_W-1:0] plan_edges [MAX_BINS+1];
   int                burst_left;

   histogram_bin_finder #(
      .MAX_BINS(MAX_BINS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_edge_index (req_edge_index),
      .req_edge_value (req_edge_value),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_bin_index  (rsp_bin_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // everything is sampled at the edge that takes it: csr writes, accepted words, strobes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.set_register(csr_index, csr_wdata);
         if (start && !busy) sb.note_word({req_func, req_edge_index, req_edge_value, req_sample});
         if (rsp_valid) sb.check_bin(rsp_bin_index);
      end
   end

   // present one word and hold it until the block takes it; bursts with random gaps
   task automatic issue_word(logic func, logic [IDX_W-1:0] index, logic [DATA_W-1:0] value,
                             logic [DATA_W-1:0] sample);
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         // gaps up to a bit over one find, so they land on every step of the cell walk
         if ($urandom_range(3, 0) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(LATENCY + 8, 1)) @(posedge clock);
         end
      end
      burst_left--;
      req_func       <= func;
      req_edge_index <= index;
      req_edge_value <= value;
      req_sample     <= sample;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // unused fields of a word carry random bits
   task automatic find_bin_of(logic [DATA_W-1:0] sample);
      issue_word(FUNC_FIND, IDX_W'($urandom), $urandom, sample);
   endtask

   task automatic load_edge(logic [IDX_W-1:0] index, logic [DATA_W-1:0] value);
      if (index <= MAX_BINS) plan_edges[index] = value;
      issue_word(FUNC_LOAD, index, value, $urandom);
   endtask

   // all finds answered and the row drained, so registers may change
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending_bins.size() != 0 || busy) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic mode, logic [6:0] count, logic [DATA_W-1:0] low,
                                 logic [DATA_W-1:0] high);
      wait_idle();
      plan_mode = mode;
      plan_bins = sb.bins_in_use(int'(count));
      plan_low  = low;
      plan_high = high;
      write_csr(CSR_BINNING_MODE, DATA_W'(mode));
      write_csr(CSR_BIN_COUNT, DATA_W'(count));
      write_csr(CSR_RANGE_LOW, low);
      write_csr(CSR_RANGE_HIGH, high);
      csr_we <= 1'b0;
   endtask

   // fills every edge slot that variable mode will read, mostly in ascending order
   task automatic load_edge_set();
      int vals[];
      int kind;
      int step;
      int base;
      vals = new[plan_bins + 1];
      for (int i = 0; i <= plan_bins; i++) vals[i] = int'($urandom);
      kind = $urandom_range(9, 0);
      if (kind <= 7 || kind == 9) vals.sort();
      // repeated edges
      if (kind == 6) begin
         for (int i = 1; i <= plan_bins; i++) begin
            if ($urandom_range(2, 0) == 0) vals[i] = vals[i-1];
         end
      end
      // tightly packed edges around zero
      if (kind == 7) begin
         base = int'($urandom_range(8 * 65536)) - 4 * 65536;
         step = $urandom_range(4, 1);
         for (int i = 0; i <= plan_bins; i++) vals[i] = base + i * step;
      end
      // full span, outer edges at the extremes
      if (kind == 9) begin
         vals[0] = int'(MOST_NEG);
         vals[plan_bins] = int'(MOST_POS);
      end
      // kind 8 stays unsorted
      for (int i = 0; i <= plan_bins; i++) load_edge(IDX_W'(i), vals[i]);
   endtask

   // samples aimed at the limits, the bin boundaries and the inside of the range
   function automatic logic [DATA_W-1:0] pick_sample();
      longint lo, hi, span, k, nudge;
      if (plan_mode == MODE_UNIFORM) begin
         lo = longint'(signed'(plan_low));
         hi = longint'(signed'(plan_high));
      end else begin
         lo = longint'(signed'(plan_edges[0]));
         hi = longint'(signed'(plan_edges[plan_bins]));
      end
      span  = hi - lo;
      nudge = longint'($urandom_range(2, 0)) - 1;
      case ($urandom_range(9, 0))
         0: return $urandom;
         1: return DATA_W'(lo + nudge);
         2: return DATA_W'(hi + nudge);
         3, 4: begin
            if (plan_mode == MODE_VARIABLE) begin
               k = longint'($urandom_range(plan_bins, 0));
               return DATA_W'(longint'(signed'(plan_edges[k])) + nudge);
            end
            // first sample of a uniform bin, or the last one of the bin below
            if (span > 0 && plan_bins > 1) begin
               k = longint'($urandom_range(plan_bins - 1, 1));
               nudge = longint'($urandom_range(1, 0));
               return DATA_W'(lo + (k * span + plan_bins - 1) / plan_bins - nudge);
            end
            return $urandom;
         end
         default: begin
            if (span > 0) return DATA_W'(lo + longint'($urandom_range(32'(span - 1), 0)));
            return $urandom;
         end
      endcase
      return $urandom;
   endfunction

   // mostly finds, some loads, a few loads to slots past the store that the block drops
   task automatic random_phase_words();
      int done;
      int pick;
      logic [IDX_W-1:0] index;
      done = 0;
      while (done < WORDS_PER_PHASE) begin
         pick = $urandom_range(99, 0);
         if (pick < 85) begin
            find_bin_of(pick_sample());
            done++;
         end else if (pick < 94) begin
            index = IDX_W'($urandom_range(MAX_BINS, 0));
            load_edge(index, pick[0] ? plan_edges[index] : $urandom);
            done++;
         end else begin
            load_edge(IDX_W'($urandom_range((1 << IDX_W) - 1, MAX_BINS + 1)), $urandom);
         end
      end
   endtask

   initial begin
      logic              mode;
      logic [6:0]        count;
      logic [DATA_W-1:0] lo, hi, swap;
      sb = new();
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_LOAD;
      req_edge_index <= '0;
      req_edge_value <= '0;
      req_sample     <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_BINNING_MODE;
      csr_wdata      <= '0;
      burst_left = 0;
      plan_mode  = MODE_UNIFORM;
      plan_bins  = 1;
      plan_low   = '0;
      plan_high  = Q_ONE;
      foreach (plan_edges[i]) plan_edges[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one uniform bin over [0, 1)
      find_bin_of('0);
      find_bin_of(32'h0000_8000);
      find_bin_of(Q_ONE - 1);
      find_bin_of(Q_ONE);
      find_bin_of(32'hffff_ffff);
      find_bin_of(MOST_NEG);
      find_bin_of(MOST_POS);

      // two variable bins with edges -1, 0, 1; loads past the store are dropped
      apply_settings(MODE_VARIABLE, 7'd2, MOST_NEG, MOST_POS);
      load_edge(IDX_W'(0), 32'hffff_0000);
      load_edge(IDX_W'(1), '0);
      load_edge(IDX_W'(2), Q_ONE);
      load_edge('1, '1);
      load_edge(IDX_W'(MAX_BINS + 1), MOST_NEG);
      find_bin_of(32'hfffe_ffff);
      find_bin_of(32'hffff_0000);
      find_bin_of('0);
      find_bin_of(Q_ONE - 1);
      find_bin_of(Q_ONE);
      find_bin_of(MOST_POS);
      find_bin_of(MOST_NEG);

      // zero bin count with an empty uniform range
      apply_settings(MODE_UNIFORM, 7'd0, Q_ONE, Q_ONE);
      find_bin_of(Q_ONE - 1);
      find_bin_of(Q_ONE);
      find_bin_of(MOST_POS);

      for (int phase = 0; phase < PHASES; phase++) begin
         lo = $urandom;
         hi = $urandom;
         case (phase)
            0: begin
               mode = MODE_UNIFORM; count = 7'd64; lo = MOST_NEG; hi = MOST_POS;
            end
            1: begin
               mode = MODE_VARIABLE; count = 7'd64;
            end
            2: begin
               // count past the store clamps to MAX_BINS
               mode = MODE_UNIFORM; count = 7'd127; lo = 32'hfffd_0000; hi = 32'h0005_0000;
            end
            3: begin
               mode = MODE_VARIABLE; count = 7'd65;
            end
            4: begin
               mode = MODE_VARIABLE; count = 7'd0;
            end
            5: begin
               mode = MODE_UNIFORM; count = 7'($urandom); hi = lo;
            end
            6: begin
               // reversed limits: everything under- or overflows
               mode = MODE_UNIFORM; count = 7'd64; lo = MOST_POS; hi = MOST_NEG;
            end
            7: begin
               // range one step wide
               mode = MODE_UNIFORM; count = 7'd64; lo = ($urandom >> 1) - 1; hi = lo + 1;
            end
            8: begin
               // range narrower than the bin count
               mode = MODE_UNIFORM; count = 7'd63;
               lo = ($urandom >> 1) - 32'h4000_0000; hi = lo + 40;
            end
            default: begin
               mode  = 1'($urandom_range(1, 0));
               count = ($urandom_range(3, 0) == 0) ? 7'($urandom) : 7'($urandom_range(8, 1));
               if (signed'(lo) > signed'(hi) && $urandom_range(7, 0) != 0) begin
                  swap = lo; lo = hi; hi = swap;
               end
            end
         endcase
         apply_settings(mode, count, lo, hi);
         if (mode == MODE_VARIABLE) load_edge_set();
         random_phase_words();
      end

      // let the last finds come out, with a bound in case they never do
      start <= 1'b0;
      for (int c = 0; c < 20 * LATENCY && sb.pending_bins.size() != 0; c++) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/hbf_pkg.sv
rtl/hbf_cell.sv
rtl/histogram_bin_finder.sv
dv/histogram_bin_finder_tb.sv
